### rtl/core/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a holds in a cycle -> b holds in the same cycle
`define ASSERT_IMPL(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// a holds in a cycle -> b holds in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

### rtl/core/tpld_pkg.sv
`default_nettype none

package tpld_pkg;

  localparam int NUM_LAMPS    = 48;
  localparam int STEPS        = 99;
  localparam int PHASE_OFFSET = 33;
  localparam int LEVELS       = 16;
  localparam int NUM_PHASES   = 3;
  localparam int NUM_PORTS    = NUM_LAMPS / 8;
  localparam int LAST_IV      = LEVELS - 1;

  typedef logic [6:0]           step_t;
  typedef logic [3:0]           level_t;
  typedef logic [1:0]           pulse_t;
  typedef logic [NUM_LAMPS-1:0] lamp_vec_t;
  typedef logic [5:0]           lamp_idx_t;
  typedef logic [NUM_PORTS-1:0] port_vec_t;

  typedef enum logic [1:0] {
    KIND_TICK       = 2'd0,
    KIND_ZERO_CROSS = 2'd1,
    KIND_WRITE      = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_SYNC_STEP   = 2'd0,
    REG_PULSE_STEPS = 2'd1,
    REG_PHASE_LOW   = 2'd2,
    REG_PHASE_HIGH  = 2'd3
  } reg_e;

  localparam step_t     SYNC_STEP_RESET   = 7'd6;
  localparam pulse_t    PULSE_STEPS_RESET = 2'd1;
  localparam lamp_vec_t PHASE_LOW_RESET   = 48'h0000_0000_0000;
  localparam lamp_vec_t PHASE_HIGH_RESET  = 48'hFFFF_FE80_0000;

  // phase raster origins
  localparam step_t PHASE_BASE [NUM_PHASES] = '{
    step_t'(0),
    step_t'(PHASE_OFFSET % STEPS),
    step_t'((2 * PHASE_OFFSET) % STEPS)
  };

  // interval lengths, last entry replaced by the pulse length
  localparam int IV_LEN [LEVELS] = '{0, 30, 8, 7, 6, 5, 5, 4, 4, 4, 3, 4, 4, 5, 6, 5};

  // start of interval i relative to its phase origin
  function automatic step_t iv_start(input int i);
    int acc;
    acc = 0;
    for (int k = 0; k < LEVELS - 1; k++) begin
      if (k <= i) acc = acc + IV_LEN[k];
    end
    return step_t'(acc);
  endfunction

  typedef struct packed {
    logic   hit;
    level_t idx;
  } iv_t;

endpackage

`default_nettype wire

### rtl/core/tpld_cmd_if.sv
`default_nettype none

interface tpld_cmd_if;
  import tpld_pkg::*;

  logic      valid;
  logic      ready;
  logic [1:0] kind;
  lamp_idx_t lamp_index;
  level_t    brightness;

  modport source (output valid, output kind, output lamp_index, output brightness,
                  input ready);
  modport sink   (input valid, input kind, input lamp_index, input brightness,
                  output ready);
endinterface

`default_nettype wire

### rtl/core/tpld_res_if.sv
`default_nettype none

interface tpld_res_if;
  import tpld_pkg::*;

  logic      valid;
  logic      ready;
  lamp_vec_t lamp_outputs;
  port_vec_t changed_ports;

  modport source (output valid, output lamp_outputs, output changed_ports, input ready);
  modport sink   (input valid, input lamp_outputs, input changed_ports, output ready);
endinterface

`default_nettype wire

### rtl/core/tpld_interval.sv
`default_nettype none

module tpld_interval (
  input  tpld_pkg::step_t  step,
  input  tpld_pkg::step_t  base,
  input  tpld_pkg::pulse_t pulse,
  output tpld_pkg::iv_t    iv
);
  import tpld_pkg::*;

  logic [7:0] rel_wide;
  step_t      rel;
  logic [7:0] last_wide;
  step_t      last_start;

  // step relative to the phase origin, modulo the raster
  always_comb begin
    if (step >= base) begin
      rel_wide = {1'b0, step} - {1'b0, base};
    end else begin
      rel_wide = {1'b0, step} + 8'(STEPS) - {1'b0, base};
    end
    rel = rel_wide[6:0];
  end

  // clearing interval follows interval 14 by the pulse length
  always_comb begin
    last_wide = {1'b0, iv_start(LAST_IV - 1)} + {6'd0, pulse};
    if (last_wide >= 8'(STEPS)) begin
      last_wide = last_wide - 8'(STEPS);
    end
    last_start = last_wide[6:0];
  end

  // higher interval wins where starts coincide
  always_comb begin
    iv = '0;
    for (int i = 0; i < LAST_IV; i++) begin
      if (rel == iv_start(i)) begin
        iv.hit = 1'b1;
        iv.idx = level_t'(i);
      end
    end
    if (rel == last_start) begin
      iv.hit = 1'b1;
      iv.idx = level_t'(LAST_IV);
    end
  end
endmodule

`default_nettype wire

### rtl/core/three_phase_lamp_dimmer.sv
// channel  dir  handshake     payload
// cmd      in   valid/ready   kind, lamp_index, brightness
// res      out  valid/ready   lamp_outputs, changed_ports (one item per step tick)
// wr_*     in   write enable  wr_index, wr_data
//
// one item per cycle unless a tick waits behind a held result; an item sits in the input register,
// and a tick's result shows in the result register on the following cycle.
// all tick work is one pass of per-lamp compare logic behind the input register.
// rst is synchronous, active high: state, levels and config registers go to defaults.
// a tick waits in the input register only while an untaken result is held.
`default_nettype none

`include "assert_macros.svh"

module three_phase_lamp_dimmer (
  input  logic                 clk,
  input  logic                 rst,
  tpld_cmd_if.sink             cmd,
  tpld_res_if.source           res,
  input  logic                 wr_en,
  input  logic [1:0]           wr_index,
  input  tpld_pkg::lamp_vec_t  wr_data
);
  import tpld_pkg::*;

  // configuration registers
  step_t     sync_step;
  pulse_t    pulse_steps;
  lamp_vec_t phase_low;
  lamp_vec_t phase_high;

  // input register
  logic      s1_valid;
  logic [1:0] s1_kind;
  lamp_idx_t s1_index;
  level_t    s1_bright;

  // dimmer state
  step_t     step_counter;
  logic      resync_pending;
  level_t    live_level    [NUM_LAMPS];
  level_t    latched_level [NUM_LAMPS];
  lamp_vec_t output_bits;

  // result register
  logic      res_valid;
  port_vec_t changed_ports;

  logic      s1_tick;
  logic      s1_go;
  logic      tick_go;
  step_t     sync_mod;
  step_t     cur_step;
  step_t     next_step;
  iv_t       phase_iv    [NUM_PHASES];
  logic      latch_phase [NUM_PHASES];
  lamp_vec_t set_bits;
  lamp_vec_t clr_bits;
  lamp_vec_t unassigned;
  lamp_vec_t output_bits_next;
  port_vec_t changed_next;
  logic      latch_lamp  [NUM_LAMPS];

  // handshake: a tick may only move on when the result slot frees up
  assign s1_tick   = s1_valid && (s1_kind == KIND_TICK);
  assign s1_go     = s1_valid && (!s1_tick || !res_valid || res.ready);
  assign tick_go   = s1_go && s1_tick;
  assign cmd.ready = !s1_valid || s1_go;

  assign res.valid         = res_valid;
  assign res.lamp_outputs  = output_bits;
  assign res.changed_ports = changed_ports;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_step   <= SYNC_STEP_RESET;
      pulse_steps <= PULSE_STEPS_RESET;
      phase_low   <= PHASE_LOW_RESET;
      phase_high  <= PHASE_HIGH_RESET;
    end else if (wr_en) begin
      case (reg_e'(wr_index))
        REG_SYNC_STEP:   sync_step   <= wr_data[6:0];
        REG_PULSE_STEPS: pulse_steps <= wr_data[1:0];
        REG_PHASE_LOW:   phase_low   <= wr_data;
        REG_PHASE_HIGH:  phase_high  <= wr_data;
        default: ;
      endcase
    end
  end

  // input register, loaded whenever the previous item moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ready && cmd.valid) begin
      s1_kind   <= cmd.kind;
      s1_index  <= cmd.lamp_index;
      s1_bright <= cmd.brightness;
    end
  end

  // counter value for this tick, with a pending resync folded in
  always_comb begin
    sync_mod = (sync_step >= step_t'(STEPS)) ? sync_step - step_t'(STEPS) : sync_step;
    cur_step = resync_pending ? sync_mod : step_counter;
    next_step = (cur_step == step_t'(STEPS - 1)) ? '0 : cur_step + 7'd1;
  end

  // interval decode per phase
  for (genvar p = 0; p < NUM_PHASES; p++) begin : g_phase
    tpld_interval u_interval (
      .step  (cur_step),
      .base  (PHASE_BASE[p]),
      .pulse (pulse_steps),
      .iv    (phase_iv[p])
    );
    // a phase latches when the counter moves onto its interval 0
    assign latch_phase[p] = (next_step == PHASE_BASE[p]);
  end

  // per-lamp switch-on and clear, by the lamp's phase code
  always_comb begin
    for (int n = 0; n < NUM_LAMPS; n++) begin
      set_bits[n]   = 1'b0;
      clr_bits[n]   = 1'b0;
      unassigned[n] = 1'b0;
      latch_lamp[n] = 1'b0;
      case ({phase_high[n], phase_low[n]})
        2'd0, 2'd1, 2'd2: begin
          if (phase_iv[{phase_high[n], phase_low[n]}].hit) begin
            // level 0 never matches: its switch-on would be the clearing interval
            set_bits[n] = (latched_level[n] != '0) &&
                          (level_t'(LAST_IV) - latched_level[n] ==
                           phase_iv[{phase_high[n], phase_low[n]}].idx);
            clr_bits[n] = (phase_iv[{phase_high[n], phase_low[n]}].idx ==
                           level_t'(LAST_IV));
          end
          latch_lamp[n] = latch_phase[{phase_high[n], phase_low[n]}];
        end
        default: begin
          // unassigned lamp: no phase drives it
          unassigned[n] = 1'b1;
        end
      endcase
    end
    output_bits_next = (output_bits & ~clr_bits) | set_bits;
    for (int q = 0; q < NUM_PORTS; q++) begin
      changed_next[q] = |(output_bits_next[8*q +: 8] ^ output_bits[8*q +: 8]);
    end
  end

  // dimmer state advances as each item leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_counter   <= '0;
      resync_pending <= 1'b0;
      output_bits    <= '0;
      for (int n = 0; n < NUM_LAMPS; n++) begin
        live_level[n]    <= '0;
        latched_level[n] <= '0;
      end
    end else if (s1_go) begin
      case (kind_e'(s1_kind))
        KIND_TICK: begin
          resync_pending <= 1'b0;
          step_counter   <= next_step;
          output_bits    <= output_bits_next;
          for (int n = 0; n < NUM_LAMPS; n++) begin
            if (latch_lamp[n]) latched_level[n] <= live_level[n];
          end
        end
        KIND_ZERO_CROSS: begin
          resync_pending <= 1'b1;
        end
        KIND_WRITE: begin
          // writes past the last lamp are dropped
          if (s1_index < lamp_idx_t'(NUM_LAMPS)) begin
            live_level[s1_index[5:0]] <= s1_bright;
          end
        end
        default: ;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (tick_go) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tick_go) changed_ports <= changed_next;
  end

  `ASSERT_IMPL(a_step_range, clk, rst, 1'b1, step_counter < step_t'(STEPS), "step counter out of raster")
  `ASSERT_IMPL(a_tick_stall, clk, rst, s1_tick && res_valid && !res.ready, !cmd.ready, "tick passed a held result")
  `ASSERT_NEXT(a_changed_match, clk, rst, tick_go, (changed_ports != '0) == (output_bits != $past(output_bits)), "changed ports disagree with outputs")
  `ASSERT_NEXT(a_unassigned_hold, clk, rst, tick_go, ((output_bits ^ $past(output_bits)) & $past(unassigned)) == '0, "unassigned lamp switched")

endmodule

`default_nettype wire

### test/tb_three_phase_lamp_dimmer.sv
`timescale 1ns / 100ps

module tb_three_phase_lamp_dimmer;
  import tpld_pkg::*;

  // raster geometry and interval table of the dimmer
  localparam int LAMPS       = 48;
  localparam int RASTER      = 99;
  localparam int PH_SHIFT    = 33;
  localparam int TOP_IV      = 15;
  localparam int NO_INTERVAL = -1;
  localparam int IV_STEPS [16] = '{0, 30, 8, 7, 6, 5, 5, 4, 4, 4, 3, 4, 4, 5, 6, 5};

  // kind code the block has to drop
  localparam logic [1:0] KIND_RESERVED = 2'd3;

  // generous cycle budget for the whole run
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [1:0] kind;
    lamp_idx_t  lamp;
    level_t     level;
    bit         drain_first;  // hold this item back until every frame is in
  } cmd_item_t;

  typedef struct packed {
    lamp_vec_t lamps;
    port_vec_t ports;
  } lamp_frame_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      wr_en;
  logic [1:0] wr_index;
  lamp_vec_t wr_data;

  tpld_cmd_if cmd_ch ();
  tpld_res_if res_ch ();

  three_phase_lamp_dimmer u_top (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd_ch.sink),
    .res      (res_ch.source),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // items waiting for the driver, frames waiting for the block
  cmd_item_t   cmd_pending [$];
  lamp_frame_t expected_frames [$];

  // predictor copy of the registers
  step_t     cfg_sync_step;
  pulse_t    cfg_pulse;
  lamp_vec_t cfg_low;
  lamp_vec_t cfg_high;

  // predictor copy of the dimmer state
  int        raster_pos;
  bit        resync_armed;
  level_t    set_level [LAMPS];
  level_t    held_level [LAMPS];
  lamp_vec_t lamp_state;

  // handshake bookkeeping and idle generation
  bit        cmd_accepted;
  int        send_gap;
  int        source_calm;
  int        stall_left;
  int        sink_calm;
  cmd_item_t next_cmd;
  lamp_frame_t got_frame;
  lamp_frame_t want_frame;

  // run statistics
  int fail_count;
  int tick_count;
  int write_count;
  int zero_cross_count;
  int ignored_count;
  int change_count;
  int setting_count;
  int drain_count;
  int cycle_count;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // phase code of a lamp: 0 R, 1 S, 2 T, 3 unassigned
  function automatic int lamp_phase(input int n);
    return int'({cfg_high[n], cfg_low[n]});
  endfunction

  // highest-numbered interval of phase ph starting at step s
  function automatic int interval_starting(input int s, input int ph);
    int origin;
    int acc;
    int hit;
    origin = (ph * PH_SHIFT) % RASTER;
    acc = 0;
    hit = NO_INTERVAL;
    for (int i = 0; i < 16; i++) begin
      acc += (i == TOP_IV) ? int'(cfg_pulse) : IV_STEPS[i];
      if ((origin + acc) % RASTER == s) hit = i;
    end
    return hit;
  endfunction

  // one step tick: drive outputs for the current step, then move on and latch
  task automatic predict_tick();
    lamp_vec_t   set_bits;
    lamp_vec_t   clear_bits;
    lamp_vec_t   next_bits;
    lamp_vec_t   diff;
    bit          any_start;
    int          iv;
    lamp_frame_t frame;
    set_bits = '0;
    clear_bits = '0;
    any_start = 1'b0;
    frame.ports = '0;
    if (resync_armed) begin
      resync_armed = 1'b0;
      raster_pos = int'(cfg_sync_step) % RASTER;
    end
    for (int p = 0; p < 3; p++) begin
      iv = interval_starting(raster_pos, p);
      if (iv != NO_INTERVAL) begin
        any_start = 1'b1;
        for (int n = 0; n < LAMPS; n++) begin
          if (lamp_phase(n) == p) begin
            if (held_level[n] != 0 && TOP_IV - int'(held_level[n]) == iv) set_bits[n] = 1'b1;
            if (iv == TOP_IV) clear_bits[n] = 1'b1;
          end
        end
      end
    end
    // a step with no interval start keeps the outputs as they are
    next_bits = any_start ? ((lamp_state & ~clear_bits) | set_bits) : lamp_state;
    diff = next_bits ^ lamp_state;
    for (int b = 0; b < NUM_PORTS; b++) frame.ports[b] = |diff[8*b +: 8];
    lamp_state = next_bits;
    frame.lamps = next_bits;
    raster_pos = (raster_pos + 1) % RASTER;
    // a phase takes its live levels when the counter lands on its interval 0
    for (int p = 0; p < 3; p++) begin
      if (interval_starting(raster_pos, p) == 0) begin
        for (int n = 0; n < LAMPS; n++) begin
          if (lamp_phase(n) == p) held_level[n] = set_level[n];
        end
      end
    end
    expected_frames.push_back(frame);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // monitor: register mirror, item prediction and frame checking at posedge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      cmd_accepted <= 1'b0;
      cfg_sync_step = 7'd6;
      cfg_pulse = 2'd1;
      cfg_low = 48'h0000_0000_0000;
      cfg_high = 48'hFFFF_FE80_0000;
      raster_pos = 0;
      resync_armed = 1'b0;
      lamp_state = '0;
      for (int n = 0; n < LAMPS; n++) begin
        set_level[n] = '0;
        held_level[n] = '0;
      end
    end else begin
      // register writes must only come while the block is idle; neither the block nor this mirror enforces it
      if (wr_en) begin
        case (wr_index)
          REG_SYNC_STEP:   cfg_sync_step = wr_data[6:0];
          REG_PULSE_STEPS: cfg_pulse = wr_data[1:0];
          REG_PHASE_LOW:   cfg_low = wr_data;
          REG_PHASE_HIGH:  cfg_high = wr_data;
          default: ;
        endcase
      end

      cmd_accepted <= cmd_ch.valid && cmd_ch.ready;
      if (cmd_ch.valid && cmd_ch.ready) begin
        case (cmd_ch.kind)
          KIND_TICK: begin
            tick_count++;
            predict_tick();
          end
          KIND_ZERO_CROSS: begin
            zero_cross_count++;
            resync_armed = 1'b1;
          end
          KIND_WRITE: begin
            // writes past the last lamp are dropped
            if (cmd_ch.lamp_index < LAMPS) begin
              write_count++;
              set_level[cmd_ch.lamp_index] = cmd_ch.brightness;
            end else begin
              ignored_count++;
            end
          end
          default: ignored_count++;
        endcase
      end

      if (res_ch.valid && res_ch.ready) begin
        got_frame.lamps = res_ch.lamp_outputs;
        got_frame.ports = res_ch.changed_ports;
        if (got_frame.ports != '0) change_count++;
        if (expected_frames.size() == 0) begin
          note_failure($sformatf("frame with nothing expected: lamps %h ports %b",
                                 got_frame.lamps, got_frame.ports));
        end else begin
          want_frame = expected_frames.pop_front();
          if (got_frame.lamps !== want_frame.lamps)
            note_failure($sformatf("lamp_outputs expected %h got %h",
                                   want_frame.lamps, got_frame.lamps));
          if (got_frame.ports !== want_frame.ports)
            note_failure($sformatf("changed_ports expected %b got %b",
                                   want_frame.ports, got_frame.ports));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // idle patterns: mostly short gaps, a few long ones, and calm stretches
  // ---------------------------------------------------------------------------
  function automatic int idle_length(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      calm = $urandom_range(20, 60);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 97) return $urandom_range(3, 8);
    return $urandom_range(15, 40);
  endfunction

  // command driver: one item per handshake, changes land on the falling edge
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_accepted) begin
      if (send_gap > 0) begin
        cmd_ch.valid <= 1'b0;
        send_gap--;
      end else if (cmd_pending.size() != 0 &&
                   !(cmd_pending[0].drain_first && expected_frames.size() != 0)) begin
        next_cmd = cmd_pending.pop_front();
        if (next_cmd.drain_first) drain_count++;
        cmd_ch.valid      <= 1'b1;
        cmd_ch.kind       <= next_cmd.kind;
        cmd_ch.lamp_index <= next_cmd.lamp;
        cmd_ch.brightness <= next_cmd.level;
        send_gap = idle_length(source_calm);
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // result sink: random back-pressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      res_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      res_ch.ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = idle_length(sink_calm);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic push_cmd(input logic [1:0] kind, input lamp_idx_t lamp, input level_t level,
                          input bit drain_first);
    cmd_item_t item;
    item.kind = kind;
    item.lamp = lamp;
    item.level = level;
    item.drain_first = drain_first;
    cmd_pending.push_back(item);
  endtask

  // mains-like traffic: a zero-cross, about a half wave of ticks with level
  // writes mixed in, now and then a cut-short half wave, stray events and junk
  task automatic queue_mains_traffic(input int count);
    int since_zc;
    int half_len;
    int r;
    cmd_item_t item;
    since_zc = 0;
    half_len = $urandom_range(92, 110);
    for (int k = 0; k < count; k++) begin
      item.lamp = lamp_idx_t'($urandom);
      item.level = level_t'($urandom);
      item.drain_first = ($urandom_range(0, 99) == 0);
      r = $urandom_range(0, 99);
      if (since_zc >= half_len) begin
        item.kind = KIND_ZERO_CROSS;
        since_zc = 0;
        half_len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(92, 110);
      end else if (r < 72) begin
        item.kind = KIND_TICK;
        since_zc++;
      end else if (r < 94) begin
        item.kind = KIND_WRITE;
        if ($urandom_range(0, 9) != 0) item.lamp = lamp_idx_t'($urandom_range(0, LAMPS - 1));
      end else if (r < 97) begin
        item.kind = KIND_ZERO_CROSS;
      end else begin
        item.kind = KIND_RESERVED;
      end
      cmd_pending.push_back(item);
    end
  endtask

  // wait until every item is in and every frame is out, then let the
  // pipeline drain items that produce no frame
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_pending.size() != 0 || cmd_ch.valid || expected_frames.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input reg_e index, input lamp_vec_t value);
    @(negedge clk);
    wr_en    <= 1'b1;
    wr_index <= index;
    wr_data  <= value;
    @(negedge clk);
    wr_en    <= 1'b0;
  endtask

  task automatic apply_setting(input step_t sync, input pulse_t pulse,
                               input lamp_vec_t low, input lamp_vec_t high);
    wait_idle();
    write_reg(REG_SYNC_STEP, lamp_vec_t'(sync));
    write_reg(REG_PULSE_STEPS, lamp_vec_t'(pulse));
    write_reg(REG_PHASE_LOW, low);
    write_reg(REG_PHASE_HIGH, high);
    setting_count++;
  endtask

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d frames still expected",
             cycle_count, expected_frames.size());
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    cmd_ch.valid      = 1'b0;
    cmd_ch.kind       = KIND_TICK;
    cmd_ch.lamp_index = '0;
    cmd_ch.brightness = '0;
    res_ch.ready      = 1'b0;
    wr_en             = 1'b0;
    wr_index          = REG_SYNC_STEP;
    wr_data           = '0;

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // directed part on the reset setting (R: lamps 0-22 and 24, T: the rest)
    push_cmd(KIND_WRITE, 6'd0, 4'd15, 1'b0);
    push_cmd(KIND_WRITE, 6'd47, 4'd1, 1'b0);
    push_cmd(KIND_WRITE, 6'd22, 4'd8, 1'b0);
    push_cmd(KIND_WRITE, 6'd23, 4'd14, 1'b0);
    push_cmd(KIND_WRITE, 6'd24, 4'd0, 1'b0);
    // lamp index past the last lamp, then the reserved kind
    push_cmd(KIND_WRITE, 6'd63, 4'd15, 1'b0);
    push_cmd(KIND_WRITE, 6'd48, 4'd7, 1'b0);
    push_cmd(KIND_RESERVED, 6'd63, 4'd15, 1'b0);
    push_cmd(KIND_TICK, 6'd63, 4'd15, 1'b0);
    push_cmd(KIND_TICK, 6'd0, 4'd0, 1'b0);
    // resync, and two zero-crosses in a row
    push_cmd(KIND_ZERO_CROSS, 6'd0, 4'd0, 1'b0);
    push_cmd(KIND_TICK, 6'd0, 4'd0, 1'b0);
    push_cmd(KIND_ZERO_CROSS, 6'd21, 4'd5, 1'b0);
    push_cmd(KIND_ZERO_CROSS, 6'd42, 4'd10, 1'b0);
    push_cmd(KIND_TICK, 6'd0, 4'd0, 1'b0);
    push_cmd(KIND_WRITE, 6'd47, 4'd15, 1'b0);
    push_cmd(KIND_WRITE, 6'd0, 4'd0, 1'b0);
    // sender waits for every frame before this one
    push_cmd(KIND_TICK, 6'd0, 4'd0, 1'b1);
    for (int k = 0; k < 6; k++) push_cmd(KIND_TICK, 6'd0, 4'd0, 1'b0);
    wait_idle();

    queue_mains_traffic(120);

    // lowest sync step, a pulse of two steps, random phase map
    apply_setting(7'd0, 2'd2, lamp_vec_t'({$urandom, $urandom}),
                  lamp_vec_t'({$urandom, $urandom}));
    queue_mains_traffic(110);

    // highest sync step in the raster, a pulse of one step, every lamp on phase S
    apply_setting(7'd98, 2'd1, '1, '0);
    queue_mains_traffic(100);

    // sync step past the raster, and a zero pulse so intervals 14 and 15 meet
    apply_setting(7'd127, 2'd0, lamp_vec_t'({$urandom, $urandom}),
                  lamp_vec_t'({$urandom, $urandom}));
    queue_mains_traffic(90);

    // every lamp on phase T, widest pulse field value
    apply_setting(7'd50, 2'd3, '0, '1);
    queue_mains_traffic(90);

    // no lamp assigned to any phase
    apply_setting(step_t'($urandom_range(0, 98)), 2'd2, '1, '1);
    queue_mains_traffic(40);

    apply_setting(step_t'($urandom_range(0, 98)), 2'd1, lamp_vec_t'({$urandom, $urandom}),
                  lamp_vec_t'({$urandom, $urandom}));
    queue_mains_traffic(180);

    wait_idle();
    repeat (6) @(negedge clk);

    while (expected_frames.size() != 0) begin
      want_frame = expected_frames.pop_front();
      note_failure($sformatf("frame never arrived: lamps %h ports %b",
                             want_frame.lamps, want_frame.ports));
    end

    $display("ran %0d step ticks, %0d level writes, %0d zero-crosses, %0d dropped items",
             tick_count, write_count, zero_cross_count, ignored_count);
    $display("%0d register settings, %0d frames with changed ports, %0d drain pauses",
             setting_count, change_count, drain_count);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d failures", fail_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+rtl/core
rtl/core/tpld_pkg.sv
rtl/core/tpld_cmd_if.sv
rtl/core/tpld_res_if.sv
rtl/core/tpld_interval.sv
rtl/core/three_phase_lamp_dimmer.sv
test/tb_three_phase_lamp_dimmer.sv
